[design/i2a_pkg.sv]
// Shared types, constants and helper functions for the integer to ASCII digit converter.
package i2a_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] value;
    } request_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    // Command codes; every other code behaves as pointer mode
    localparam logic [1:0] CMD_DECIMAL = 2'd0;
    localparam logic [1:0] CMD_HEX     = 2'd1;
    localparam logic [1:0] CMD_POINTER = 2'd2;

    // Digit buffer geometry
    localparam int MAX_DECIMAL_DIGITS = 20;
    localparam int VALUE_W            = 64;
    localparam int DIGIT_W            = 4;
    localparam int DIGIT_IDX_W        = 5;
    localparam int DIGIT_BUF_W        = MAX_DECIMAL_DIGITS * DIGIT_W;

    // Binary to BCD: value bits folded in per cycle, and conversion steps per value
    localparam int BITS_PER_STEP = 4;
    localparam int DABBLE_STEPS  = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = 4;

    typedef logic [MAX_DECIMAL_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // One converted request waiting for the emitter
    typedef struct packed {
        logic                   prefix;
        logic [DIGIT_IDX_W-1:0] ndig;
        digits_t                digits;
    } entry_t;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_F    = 8'h66;
    localparam logic [7:0] CHAR_X    = 8'h78;

    // One double-dabble step: correct digits of five or more, then shift one bit in
    function automatic digits_t dabble_step(input digits_t cur, input logic bit_in);
        digits_t                adj;
        logic [DIGIT_BUF_W-1:0] flat;
        adj = cur;
        for (int d = 0; d < MAX_DECIMAL_DIGITS; d++)
        begin
            if (adj[d] >= 4'd5)
            begin
                adj[d] = adj[d] + 4'd3;
            end
        end
        flat = adj;
        return digits_t'({flat[DIGIT_BUF_W-2:0], bit_in});
    endfunction

    // Number of significant digits, at least one
    function automatic logic [DIGIT_IDX_W-1:0] count_digits(input digits_t digs);
        logic [DIGIT_IDX_W-1:0] n;
        n = DIGIT_IDX_W'(1);
        for (int d = 0; d < MAX_DECIMAL_DIGITS; d++)
        begin
            if (digs[d] != '0)
            begin
                n = DIGIT_IDX_W'(d + 1);
            end
        end
        return n;
    endfunction

    // Digit to lowercase ASCII
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            c = CHAR_A + {4'b0000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

[design/i2a_front.sv]
// Front end: accepts a request, classifies the command and builds the digit buffer.
module i2a_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  i2a_pkg::request_t   request,
    output logic                busy,
    output logic                push,
    output i2a_pkg::entry_t     entry,
    input  logic                full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t                        state_reg, state_next;
    i2a_pkg::digits_t                    bcd_reg, bcd_next;
    logic [i2a_pkg::VALUE_W-1:0]         bin_reg, bin_next;
    logic [i2a_pkg::STEP_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                pfx_reg, pfx_next;
    i2a_pkg::digits_t                    bcd_step;

    // Fold the next four value bits into the BCD buffer
    always_comb
    begin
        bcd_step = bcd_reg;
        for (int k = 0; k < i2a_pkg::BITS_PER_STEP; k++)
        begin
            bcd_step = i2a_pkg::dabble_step(bcd_step, bin_reg[i2a_pkg::VALUE_W-1-k]);
        end
    end

    // Sequence: classify, convert, hand over to the queue
    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        pfx_next   = pfx_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    bin_next = request.value;
                    cnt_next = '0;
                    unique case (request.command)
                        i2a_pkg::CMD_DECIMAL:
                        begin
                            pfx_next   = 1'b0;
                            bcd_next   = '0;
                            state_next = F_CONV;
                        end
                        i2a_pkg::CMD_HEX:
                        begin
                            pfx_next   = 1'b0;
                            bcd_next   = i2a_pkg::digits_t'({16'h0000, request.value});
                            state_next = F_PUSH;
                        end
                        default:
                        begin
                            pfx_next   = 1'b1;
                            bcd_next   = i2a_pkg::digits_t'({16'h0000, request.value});
                            state_next = F_PUSH;
                        end
                    endcase
                end
            end
            F_CONV:
            begin
                bcd_next = bcd_step;
                bin_next = bin_reg << i2a_pkg::BITS_PER_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == i2a_pkg::STEP_CNT_W'(i2a_pkg::DABBLE_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
        cnt_reg <= cnt_next;
        pfx_reg <= pfx_next;
    end

    assign busy         = (state_reg != F_IDLE);
    assign push         = (state_reg == F_PUSH) && !full;
    assign entry.prefix = pfx_reg;
    assign entry.ndig   = i2a_pkg::count_digits(bcd_reg);
    assign entry.digits = bcd_reg;

endmodule

[design/i2a_fifo.sv]
// Short queue of converted requests between the front end and the emitter.
module i2a_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2a_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output i2a_pkg::entry_t rd_entry,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2a_pkg::entry_t    slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    // Store on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign rd_entry = slots[rd_ptr_reg];
    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);

endmodule

[design/i2a_back.sv]
// Emitter: takes converted requests from the queue and, within a request, sends one character per cycle.
module i2a_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  i2a_pkg::entry_t   rd_entry,
    output logic              pop,
    output logic              strobe,
    output i2a_pkg::result_t  result
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PFX0 = 4'b0010,
        B_PFX1 = 4'b0100,
        B_DIG  = 4'b1000
    } back_state_t;

    back_state_t                        state_reg, state_next;
    i2a_pkg::digits_t                   digits_reg, digits_next;
    logic [i2a_pkg::DIGIT_IDX_W-1:0]    idx_reg, idx_next;
    logic                               strobe_reg, strobe_next;
    i2a_pkg::result_t                   result_reg, result_next;

    // Walk prefix then digits, most significant first
    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    digits_next = rd_entry.digits;
                    idx_next    = rd_entry.ndig - 1'b1;
                    state_next  = rd_entry.prefix ? B_PFX0 : B_DIG;
                end
            end
            B_PFX0:
            begin
                strobe_next           = 1'b1;
                result_next.character = i2a_pkg::CHAR_ZERO;
                result_next.last      = 1'b0;
                state_next            = B_PFX1;
            end
            B_PFX1:
            begin
                strobe_next           = 1'b1;
                result_next.character = i2a_pkg::CHAR_X;
                result_next.last      = 1'b0;
                state_next            = B_DIG;
            end
            B_DIG:
            begin
                strobe_next           = 1'b1;
                result_next.character = i2a_pkg::digit_char(digits_reg[idx_reg]);
                result_next.last      = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[design/integer_to_ascii_digits.sv]
// Integer to ASCII digits: top level joining front end, request queue and emitter.
//
// A request (command, 64-bit value) is taken when start is high and busy is low. Decimal
// requests pass through the binary-to-BCD unit (four value bits per cycle), then count
// digits and enter the queue; hex and pointer requests go straight to that last step.
// busy stays high from acceptance until the request is in the queue, or while the
// queue is full. The emitter sends one character per cycle with strobe high for exactly
// that cycle (1 to 20 characters for decimal, up to 16 for hex, up to 18 for pointer),
// then takes the next request from the queue. Conversion of one request overlaps
// emission of earlier ones, so the sustained rate is set by the emitter and, for decimal
// requests, also by the front end, which accepts, converts and queues each in turn.
// The receiver cannot stall: every strobed character must be taken.
module integer_to_ascii_digits #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  i2a_pkg::request_t request,
    output logic              busy,
    output logic              strobe,
    output i2a_pkg::result_t  result
);

    logic            push, full, pop, empty;
    i2a_pkg::entry_t wr_entry, rd_entry;

    i2a_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .push    (push),
        .entry   (wr_entry),
        .full    (full)
    );

    i2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .rd_entry (rd_entry),
        .empty    (empty)
    );

    i2a_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .rd_entry (rd_entry),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

    // An accepted request keeps the front end occupied next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("front end idle right after accepting a request");

    // Never write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    // Never take from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    // The prefix letter always follows the prefix zero directly
    a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.character == i2a_pkg::CHAR_X |->
            $past(strobe) && $past(result.character) == i2a_pkg::CHAR_ZERO
            && !result.last)
        else $error("prefix emitted out of order");

    // Only digits, lowercase hex letters and the prefix letter are emitted
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |->
            (result.character >= i2a_pkg::CHAR_ZERO && result.character <= i2a_pkg::CHAR_NINE)
            || (result.character >= i2a_pkg::CHAR_A && result.character <= i2a_pkg::CHAR_F)
            || result.character == i2a_pkg::CHAR_X)
        else $error("character outside the digit set");

endmodule

[verif/integer_to_ascii_digits_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the integer to ASCII digit converter.
module integer_to_ascii_digits_tb;

    // Spare command code; the block treats it as pointer mode
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT          = 200000;
    localparam int RANDOM_REQUESTS      = 360;
    localparam int DRAIN_CYCLES         = 48;
    localparam int DIRECTED_ROWS        = 22;

    // One directed request; an empty text means the predictor supplies the characters
    typedef struct {
        logic [1:0]  command;
        logic [63:0] value;
        string       text;
    } stim_row_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    i2a_pkg::request_t  request = '0;
    logic               busy;
    logic               strobe;
    i2a_pkg::result_t   result;

    i2a_pkg::result_t   pending_chars[$];
    stim_row_t          dir_rows[DIRECTED_ROWS];
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;

    integer_to_ascii_digits uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Queue the characters of a typed-in text, last flag on the final one
    function automatic void load_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            pending_chars.push_back(i2a_pkg::result_t'{character: text[i],
                                                       last: (i == text.len() - 1)});
        end
    endfunction

    // Predict the text of one request: digits most significant first, optional 0x prefix
    function automatic void predict_text(input logic [1:0] cmd, input logic [63:0] val);
        logic [7:0]  chars[$];
        logic [63:0] rest;
        logic [63:0] base;
        logic [3:0]  digit;
        rest = val;
        base = (cmd == i2a_pkg::CMD_DECIMAL) ? 64'd10 : 64'd16;
        for (int n = 0; n < i2a_pkg::MAX_DECIMAL_DIGITS; n++)
        begin
            digit = 4'(rest % base);
            rest  = rest / base;
            chars.push_front(digit < 4'd10 ? i2a_pkg::CHAR_ZERO + 8'(digit)
                                           : i2a_pkg::CHAR_A + 8'(digit - 4'd10));
            if (rest == 64'd0)
                break;
        end
        if (cmd != i2a_pkg::CMD_DECIMAL && cmd != i2a_pkg::CMD_HEX)
        begin
            chars.push_front(i2a_pkg::CHAR_X);
            chars.push_front(i2a_pkg::CHAR_ZERO);
        end
        foreach (chars[i])
        begin
            pending_chars.push_back(i2a_pkg::result_t'{character: chars[i],
                                                       last: (i == chars.size() - 1)});
        end
    endfunction

    // Pick a value, biased toward digit-count boundaries in both bases
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        p = 64'd1;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            3:
            begin
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p - 64'($urandom_range(0, 1));
            end
            4: v = (64'd1 << (4 * $urandom_range(0, 15))) - 64'($urandom_range(0, 1));
            default: v = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
        endcase
        return v;
    endfunction

    // Present one request, hold it until accepted, then sometimes drop start and idle
    task automatic send_request(input logic [1:0] cmd, input logic [63:0] val,
                                input string text, input bit may_idle);
        request <= i2a_pkg::request_t'{command: cmd, value: val};
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (text.len() > 0)
            load_typed_text(text);
        else
            predict_text(cmd, val);
        if (may_idle && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected character has come out
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // Compare each strobed character with the oldest expectation
    always @(posedge clk)
    begin : check_chars
        i2a_pkg::result_t want;
        if (rst_n && $isunknown(strobe))
            report_mismatch("strobe is unknown");
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 8'h%02h last %0b",
                                          result.character, result.last));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (result.character !== want.character)
                begin
                    report_mismatch($sformatf("character 8'h%02h, wanted 8'h%02h",
                                              result.character, want.character));
                end
                if (result.last !== want.last)
                begin
                    report_mismatch($sformatf("last %0b on 8'h%02h, wanted %0b",
                                              result.last, result.character, want.last));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("integer_to_ascii_digits: mismatch");
            $finish;
        end
    end

    initial
    begin
        dir_rows = '{
            '{i2a_pkg::CMD_DECIMAL, 64'd0,                    "0"},
            '{i2a_pkg::CMD_HEX,     64'd0,                    "0"},
            '{i2a_pkg::CMD_POINTER, 64'd0,                    "0x0"},
            '{CMD_RESERVED,         64'd0,                    "0x0"},
            '{i2a_pkg::CMD_DECIMAL, ALL_ONES,                 "18446744073709551615"},
            '{i2a_pkg::CMD_HEX,     ALL_ONES,                 "ffffffffffffffff"},
            '{i2a_pkg::CMD_POINTER, ALL_ONES,                 "0xffffffffffffffff"},
            '{CMD_RESERVED,         ALL_ONES,                 "0xffffffffffffffff"},
            '{i2a_pkg::CMD_DECIMAL, 64'd9,                    "9"},
            '{i2a_pkg::CMD_DECIMAL, 64'd10,                   "10"},
            '{i2a_pkg::CMD_DECIMAL, 64'd9999999999999999999,  "9999999999999999999"},
            '{i2a_pkg::CMD_DECIMAL, 64'd10000000000000000000, "10000000000000000000"},
            '{i2a_pkg::CMD_HEX,     64'ha,                    "a"},
            '{i2a_pkg::CMD_HEX,     64'hf,                    "f"},
            '{i2a_pkg::CMD_HEX,     64'h10,                   "10"},
            '{i2a_pkg::CMD_POINTER, 64'h1,                    "0x1"},
            '{CMD_RESERVED,         64'habc,                  "0xabc"},
            '{i2a_pkg::CMD_DECIMAL, 64'd1234567890123,        ""},
            '{i2a_pkg::CMD_HEX,     64'h0123_4567_89ab_cdef,  ""},
            '{i2a_pkg::CMD_POINTER, 64'h8000_0000_0000_0000,  ""},
            '{i2a_pkg::CMD_DECIMAL, 64'h5555_5555_5555_5555,  ""},
            '{CMD_RESERVED,         64'h2aaa_aaaa_aaaa_aaaa,  ""}
        };

        // Hold reset, then release on a clock edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].command, dir_rows[i].value, dir_rows[i].text, 1'b1);
        drain_results();

        // Random requests; a middle stretch runs back to back, and one pause empties the block
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k == RANDOM_REQUESTS / 2)
                drain_results();
            send_request(2'($urandom_range(0, 3)), random_value(), "", !(k >= 100 && k < 200));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("integer_to_ascii_digits: match");
        else
            $display("integer_to_ascii_digits: mismatch");
        $finish;
    end

endmodule
